// ===== src/rnp_pkg.sv =====
// Shared types and constants for the RTP NAL packetizer.
// Holds the burst descriptor passed from the NAL controller to the byte emitter.
// No dependencies.
package rnp_pkg;

    // One burst holds every datagram byte caused by one NAL byte
    localparam int unsigned BURST_BYTES = 16;

    typedef logic [0:BURST_BYTES-1][7:0] burst_bytes_t;
    typedef logic [$clog2(BURST_BYTES)-1:0] burst_idx_t;

    typedef struct packed {
        burst_bytes_t bytes;    // bytes sent from index start up to the last index
        burst_idx_t   start;    // first index that carries data
        logic         pkt_end;  // last byte closes the datagram
    } burst_t;

    // Start index of each burst layout (payload byte always sits last)
    localparam burst_idx_t LAST_IDX        = burst_idx_t'(BURST_BYTES - 1);
    localparam burst_idx_t START_BYTE_ONLY = burst_idx_t'(BURST_BYTES - 1);
    localparam burst_idx_t START_SINGLE    = burst_idx_t'(BURST_BYTES - 13);
    localparam burst_idx_t START_FU_H264   = burst_idx_t'(BURST_BYTES - 15);
    localparam burst_idx_t START_FU_H265   = burst_idx_t'(BURST_BYTES - 16);

    // Configuration register indexes
    localparam logic CFG_CODEC_H265  = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    // RTP header fields
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [6:0]  RTP_PT           = 7'd96;
    localparam logic [31:0] RTP_SSRC         = 32'h1234_5678;
    localparam logic [31:0] TS_SCALE         = 32'd90;

    // Fragmentation unit codes
    localparam logic [7:0]  FU_TYPE_H264     = 8'd28;
    localparam logic [7:0]  FU_IND_H265      = 8'd98;   // type 49 shifted into place
    localparam logic [7:0]  FU_H264_NRI_MASK = 8'h60;
    localparam logic [7:0]  FU_H265_HDR_MASK = 8'h81;
    localparam logic [15:0] FU_HEAD_H264     = 16'd2;
    localparam logic [15:0] FU_HEAD_H265     = 16'd3;

    // NAL types that leave the marker clear in H.264 single packets
    localparam logic [4:0]  H264_TYPE_SEI = 5'd6;
    localparam logic [4:0]  H264_TYPE_SPS = 5'd7;
    localparam logic [4:0]  H264_TYPE_PPS = 5'd8;

    localparam logic [23:0] NAL_MIN_LEN       = 24'd4;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;

endpackage

// ===== src/rnp_nal_ctrl.sv =====
// NAL tracking, configuration registers and burst building for the packetizer.
// Each accepted NAL byte that yields output is turned into one burst descriptor in a single pass.
// Depends on rnp_pkg.
module rnp_nal_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_nal_byte,
    input  logic [23:0]     s_nal_length,
    input  logic [31:0]     s_time_ms,
    input  logic            take,
    output logic            pend_valid,
    output rnp_pkg::burst_t pend_burst
);

    // configuration
    logic        codec_reg;
    logic [15:0] mp_reg;

    // NAL state
    logic [15:0] seq_reg, seq_next;
    logic [23:0] pos_reg, pos_next;
    logic [23:0] remain_reg, remain_next;
    logic [15:0] fill_reg, fill_next;
    logic [7:0]  hdr0_reg, hdr0_next;
    logic [7:0]  hdr1_reg, hdr1_next;
    logic        frag_reg, frag_next;
    logic        first_pend_reg, first_pend_next;
    logic        drop_reg, drop_next;
    logic        h265_reg, h265_next;
    logic [15:0] chunk_reg, chunk_next;

    // output register toward the emitter
    logic            pend_valid_reg, pend_valid_next;
    rnp_pkg::burst_t pend_burst_reg, pend_burst_next;

    logic        accept;
    logic        emit;
    logic [31:0] ts;
    logic [23:0] len_eff;
    logic [23:0] remain_cur;
    logic [15:0] head;
    logic        marker;
    logic        last_frag;
    logic        end_c;
    logic [5:0]  frag_type;
    logic [7:0]  fu_hdr;
    logic [95:0] rtp_hdr;
    logic [4:0]  h264_type;

    assign s_ready    = !pend_valid_reg || take;
    assign accept     = s_valid && s_ready;
    assign pend_valid = pend_valid_reg;
    assign pend_burst = pend_burst_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= 1'b0;
            mp_reg    <= rnp_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rnp_pkg::CFG_CODEC_H265:  codec_reg <= cfg_wr_data[0];
                rnp_pkg::CFG_MAX_PAYLOAD: mp_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= '0;
            pos_reg        <= '0;
            remain_reg     <= '0;
            fill_reg       <= '0;
            hdr0_reg       <= '0;
            hdr1_reg       <= '0;
            frag_reg       <= 1'b0;
            first_pend_reg <= 1'b0;
            drop_reg       <= 1'b0;
            h265_reg       <= 1'b0;
            chunk_reg      <= 16'd1;
            pend_valid_reg <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            pos_reg        <= pos_next;
            remain_reg     <= remain_next;
            fill_reg       <= fill_next;
            hdr0_reg       <= hdr0_next;
            hdr1_reg       <= hdr1_next;
            frag_reg       <= frag_next;
            first_pend_reg <= first_pend_next;
            drop_reg       <= drop_next;
            h265_reg       <= h265_next;
            chunk_reg      <= chunk_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // burst payload, no reset
    always_ff @(posedge aclk) begin
        pend_burst_reg <= pend_burst_next;
    end

    // timestamp and shared header pieces
    assign ts        = s_time_ms * rnp_pkg::TS_SCALE;
    assign len_eff   = (s_nal_length == 24'd0) ? 24'd1 : s_nal_length;
    assign h264_type = s_nal_byte[4:0];
    assign frag_type = h265_reg ? hdr0_reg[6:1] : {1'b0, hdr0_reg[4:0]};
    assign rtp_hdr   = {rnp_pkg::RTP_VERSION_BYTE, marker, rnp_pkg::RTP_PT,
                        seq_reg, ts, rnp_pkg::RTP_SSRC};
    assign fu_hdr    = {first_pend_reg, last_frag, frag_type};

    // per-byte decision
    always_comb begin
        seq_next        = seq_reg;
        pos_next        = pos_reg;
        remain_next     = remain_reg;
        fill_next       = fill_reg;
        hdr0_next       = hdr0_reg;
        hdr1_next       = hdr1_reg;
        frag_next       = frag_reg;
        first_pend_next = first_pend_reg;
        drop_next       = drop_reg;
        h265_next       = h265_reg;
        chunk_next      = chunk_reg;
        remain_cur      = remain_reg;
        head            = codec_reg ? rnp_pkg::FU_HEAD_H265 : rnp_pkg::FU_HEAD_H264;
        marker          = 1'b0;
        last_frag       = remain_reg <= {8'd0, chunk_reg};
        end_c           = (({1'b0, fill_reg} + 17'd1) >= {1'b0, chunk_reg})
                          || (remain_reg == 24'd1);
        emit            = 1'b0;
        pend_burst_next = pend_burst_reg;

        if (accept) begin
            if (pos_reg == 24'd0) begin
                // first byte: latch NAL header and mode
                remain_cur      = len_eff;
                h265_next       = codec_reg;
                hdr0_next       = s_nal_byte;
                drop_next       = len_eff < rnp_pkg::NAL_MIN_LEN;
                frag_next       = (len_eff >= rnp_pkg::NAL_MIN_LEN)
                                  && (len_eff > {8'd0, mp_reg});
                first_pend_next = 1'b1;
                fill_next       = '0;
                chunk_next      = (mp_reg > head) ? (mp_reg - head) : 16'd1;
                if (!drop_next && !frag_next) begin
                    // whole NAL in one datagram
                    if (codec_reg) begin
                        marker = !s_nal_byte[6];
                    end else begin
                        marker = (h264_type != rnp_pkg::H264_TYPE_SEI)
                                 && (h264_type != rnp_pkg::H264_TYPE_SPS)
                                 && (h264_type != rnp_pkg::H264_TYPE_PPS);
                    end
                    emit                    = 1'b1;
                    seq_next                = seq_reg + 16'd1;
                    pend_burst_next.bytes   = {24'd0, rtp_hdr, s_nal_byte};
                    pend_burst_next.start   = rnp_pkg::START_SINGLE;
                    pend_burst_next.pkt_end = 1'b0;
                end
            end else if (drop_reg) begin
                // short NAL: swallow
            end else if (!frag_reg) begin
                emit                    = 1'b1;
                pend_burst_next.bytes   = {120'd0, s_nal_byte};
                pend_burst_next.start   = rnp_pkg::START_BYTE_ONLY;
                pend_burst_next.pkt_end = remain_reg == 24'd1;
            end else if (h265_reg && pos_reg == 24'd1) begin
                // second H.265 header byte
                hdr1_next = s_nal_byte;
            end else begin
                emit                    = 1'b1;
                pend_burst_next.pkt_end = end_c;
                fill_next               = end_c ? 16'd0 : (fill_reg + 16'd1);
                if (fill_reg == 16'd0) begin
                    // open a new fragment
                    marker          = last_frag;
                    seq_next        = seq_reg + 16'd1;
                    first_pend_next = 1'b0;
                    if (h265_reg) begin
                        pend_burst_next.bytes = {rtp_hdr,
                            rnp_pkg::FU_IND_H265 | (hdr0_reg & rnp_pkg::FU_H265_HDR_MASK),
                            hdr1_reg, fu_hdr, s_nal_byte};
                        pend_burst_next.start = rnp_pkg::START_FU_H265;
                    end else begin
                        pend_burst_next.bytes = {8'd0, rtp_hdr,
                            rnp_pkg::FU_TYPE_H264 | (hdr0_reg & rnp_pkg::FU_H264_NRI_MASK),
                            fu_hdr, s_nal_byte};
                        pend_burst_next.start = rnp_pkg::START_FU_H264;
                    end
                end else begin
                    pend_burst_next.bytes = {120'd0, s_nal_byte};
                    pend_burst_next.start = rnp_pkg::START_BYTE_ONLY;
                end
            end

            remain_next = remain_cur - 24'd1;
            pos_next    = (remain_next == 24'd0) ? 24'd0 : (pos_reg + 24'd1);
        end

        pend_valid_next = (pend_valid_reg && !take) || emit;
    end

endmodule

// ===== src/rnp_byte_emit.sv =====
// Output stage of the packetizer: holds one burst and sends it a byte per beat.
// Takes the next burst from the controller when the current one drains.
// Depends on rnp_pkg.
module rnp_byte_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pend_valid,
    input  rnp_pkg::burst_t pend_burst,
    output logic            take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_packet_end,
    output logic            m_last_of_item
);

    logic                 cur_valid_reg, cur_valid_next;
    rnp_pkg::burst_t      cur_reg, cur_next;
    rnp_pkg::burst_idx_t  idx_reg, idx_next;
    logic                 at_last;
    logic                 beat;
    logic                 load;

    assign at_last = idx_reg == rnp_pkg::LAST_IDX;
    assign beat    = cur_valid_reg && m_ready;
    assign take    = !cur_valid_reg || (m_ready && at_last);
    assign load    = pend_valid && take;

    assign m_valid        = cur_valid_reg;
    assign m_out_byte     = cur_reg.bytes[idx_reg];
    assign m_packet_end   = at_last && cur_reg.pkt_end;
    assign m_last_of_item = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
    end

    // load a new burst or step through the current one
    always_comb begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cur_valid_next = cur_valid_reg;
        if (load) begin
            cur_next       = pend_burst;
            idx_next       = pend_burst.start;
            cur_valid_next = 1'b1;
        end else if (beat) begin
            idx_next = idx_reg + 1'b1;
            if (at_last) begin
                cur_valid_next = 1'b0;
            end
        end
    end

endmodule

// ===== src/rtp_nal_packetizer.sv =====
// Top level of the RTP packetizer for H.264 / H.265 NAL units.
// Instantiates rnp_nal_ctrl and rnp_byte_emit; depends on rnp_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------
//   config  | cfg_wr_en, cfg_index, cfg_wr_data       | write on enable
//   input   | s_nal_byte, s_nal_length, s_time_ms     | s_valid/s_ready
//   output  | m_out_byte, m_packet_end, m_last_of_item| m_valid/m_ready
//
// One NAL byte is taken per cycle while it yields at most one datagram byte and m_ready is high.
// A byte that opens a datagram yields 13 to 16 output beats, and the single
// output port sends one beat per cycle while m_ready is high, so input waits while that burst drains.
// One built burst can wait in the controller's output register while the
// emitter sends the previous one. Reset is synchronous, active low, and clears
// the sequence number and all NAL tracking; max_payload returns to 1400.
module rtp_nal_packetizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_nal_byte,
    input  logic [23:0] s_nal_length,
    input  logic [31:0] s_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_packet_end,
    output logic        m_last_of_item
);

    logic            take;
    logic            pend_valid;
    rnp_pkg::burst_t pend_burst;

    rnp_nal_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_nal_byte  (s_nal_byte),
        .s_nal_length(s_nal_length),
        .s_time_ms   (s_time_ms),
        .take        (take),
        .pend_valid  (pend_valid),
        .pend_burst  (pend_burst)
    );

    rnp_byte_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pend_valid    (pend_valid),
        .pend_burst    (pend_burst),
        .take          (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_packet_end  (m_packet_end),
        .m_last_of_item(m_last_of_item)
    );

endmodule
